FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the timing recovery block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GSTR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define GSTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/gstr_pkg.sv
// Package for the Gardner symbol timing recovery block: types and fixed constants.
// No dependencies; the register block and the top level import it, and the interfaces use its timestamp width.
`default_nettype none

package gstr_pkg;

    // Width of the signed Q10.8 offset registers; they wrap at this width.
    localparam int OFF_W = 18;

    localparam logic signed [OFF_W-1:0] ONE_SAMPLE  = 18'sd256;
    localparam logic signed [OFF_W-1:0] HALF_SAMPLE = 18'sd128;

    // Configuration register widths.
    localparam int SPS_W  = 16;
    localparam int GAIN_W = 16;
    localparam int MAXC_W = 15;

    // Width of the scaled error before the clamp.
    localparam int SCALED_W = 19;

    // APB port.
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 4;
    localparam int TIME_W  = 32;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_SPS  = 2'd0,
        REG_GAIN = 2'd1,
        REG_MAXC = 2'd2,
        REG_NONE = 2'd3
    } reg_idx_t;

    localparam logic [SPS_W-1:0]  SPS_RESET  = 16'd1024;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
    localparam logic [MAXC_W-1:0] MAXC_RESET = 15'd128;

    typedef struct packed {
        logic [SPS_W-1:0]  samples_per_symbol;
        logic [GAIN_W-1:0] loop_gain;
        logic [MAXC_W-1:0] max_correction;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_ERR,
        ST_MUL_GAIN,
        ST_UPDATE
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gstr_sample_if.sv
// Input channel of the timing recovery block: one sample word with its timestamp.
// Depends on gstr_pkg for the timestamp width.
`default_nettype none

interface gstr_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                                 valid;
    logic                                 ready;
    logic signed [SAMPLE_BITS-1:0]        sample;
    logic        [gstr_pkg::TIME_W-1:0]   sample_time;

    modport source (output valid, output sample, output sample_time, input ready);
    modport sink   (input valid, input sample, input sample_time, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gstr_symbol_if.sv
// Output channel of the timing recovery block: one symbol word with its timestamp.
// Depends on gstr_pkg for the timestamp width.
`default_nettype none

interface gstr_symbol_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                                 valid;
    logic                                 ready;
    logic signed [SAMPLE_BITS-1:0]        symbol;
    logic        [gstr_pkg::TIME_W-1:0]   symbol_time;

    modport source (output valid, output symbol, output symbol_time, input ready);
    modport sink   (input valid, input symbol, input symbol_time, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gstr_apb_regs.sv
// APB configuration registers of the timing recovery block.
// Depends on gstr_pkg for the register layout and the cfg_t struct.
`default_nettype none

module gstr_apb_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gstr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [gstr_pkg::APB_DW-1:0]    pwdata,
    output logic      [gstr_pkg::APB_DW-1:0]    prdata,
    output logic                                pready,
    output gstr_pkg::cfg_t                      cfg
);
    import gstr_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    // Registers sit on word boundaries; the byte lane bits are ignored.
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SPS:  cfg_next.samples_per_symbol = pwdata[SPS_W-1:0];
                REG_GAIN: cfg_next.loop_gain          = pwdata[GAIN_W-1:0];
                REG_MAXC: cfg_next.max_correction     = pwdata[MAXC_W-1:0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SPS:  prdata = {{(APB_DW-SPS_W){1'b0}}, cfg_reg.samples_per_symbol};
            REG_GAIN: prdata = {{(APB_DW-GAIN_W){1'b0}}, cfg_reg.loop_gain};
            REG_MAXC: prdata = {{(APB_DW-MAXC_W){1'b0}}, cfg_reg.max_correction};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_symbol <= SPS_RESET;
            cfg_reg.loop_gain          <= GAIN_RESET;
            cfg_reg.max_correction     <= MAXC_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gstr_mul.sv
// Shared signed multiplier of the timing recovery block.
// Used for the error product and for the gain scaling; no package dependency.
`default_nettype none

module gstr_mul #(
    parameter int A_W = 33,
    parameter int B_W = 17
) (
    input  wire logic signed [A_W-1:0]     a,
    input  wire logic signed [B_W-1:0]     b,
    output logic signed      [A_W+B_W-1:0] p
);
    assign p = a * b;
endmodule

`default_nettype wire

FILE: hw/rtl/gardner_symbol_timing_recovery.sv
// Gardner symbol timing recovery: top level with sequencer, datapath and output register.
// Depends on gstr_pkg, gstr_sample_if, gstr_symbol_if, gstr_apb_regs, gstr_mul
// and assert_macros.svh.
//
//   channel   kind          payload                      accepted when
//   samples   stream in     sample, sample_time          valid && ready
//   symbols   stream out    symbol, symbol_time          valid && ready
//   config    APB write     pwdata at paddr 0, 4, 8      psel && penable && pwrite
//
// A sample that is not a symbol leaves the sequencer idle. A symbol sample goes through the steps
// accept, error product, gain scaling, then clamp and offset update; the one
// shared multiplier is used in the error product and gain scaling steps.
// The update cycle waits while the output register still holds an untaken word.
// Reset clears the offsets, previous symbol and latched mid sample to zero.
`default_nettype none

`include "assert_macros.svh"

module gardner_symbol_timing_recovery #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gstr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [gstr_pkg::APB_DW-1:0]    pwdata,
    output logic      [gstr_pkg::APB_DW-1:0]    prdata,
    output logic                                pready,
    gstr_sample_if.sink                         samples,
    gstr_symbol_if.source                       symbols
);
    import gstr_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int DIFF_W = SB + 1;
    localparam int PROD_W = 2 * SB + 1;
    localparam int MAG_W  = 2 * SB;
    localparam int ERR_SH = 2 * SB - 2;
    localparam int A_W    = 2 * SB + 1;
    localparam int B_W    = ((SB > GAIN_W) ? SB : GAIN_W) + 1;
    localparam int SUM_W  = MAG_W + GAIN_W + 1;
    localparam logic [SUM_W-1:0] ROUND_UP = {{(SUM_W-ERR_SH){1'b0}}, {ERR_SH{1'b1}}};

    cfg_t cfg;

    gstr_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t                   state_reg, state_next;
    logic signed [OFF_W-1:0]  sym_off_reg, sym_off_next;
    logic signed [OFF_W-1:0]  mid_off_reg, mid_off_next;
    logic signed [SB-1:0]     prev_reg, prev_next;
    logic signed [SB-1:0]     mid_reg, mid_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [SB-1:0]     sample_reg;
    logic [TIME_W-1:0]        time_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic [SCALED_W-1:0]      scaled_reg;
    logic signed [SB-1:0]     out_symbol_reg;
    logic [TIME_W-1:0]        out_time_reg;

    logic                     in_ready;
    logic                     in_fire;
    logic                     out_free;
    logic                     upd_fire;
    logic                     sym_due;
    logic                     mid_due;
    logic signed [DIFF_W-1:0] diff;
    logic                     prod_neg;
    logic [MAG_W-1:0]         mag;
    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [A_W+B_W-1:0] mul_p;
    logic [SUM_W-1:0]         scaled_sum;
    logic [MAXC_W-1:0]        clamped;
    logic signed [OFF_W-1:0]  err;
    logic signed [OFF_W-1:0]  base;
    logic [SPS_W:0]           sps_plus1;
    logic [SPS_W-1:0]         half_sps;

    gstr_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    // A symbol is due once its offset rounds to zero or below; the mid point only
    // when its offset rounds to exactly zero.
    assign sym_due = (sym_off_reg < HALF_SAMPLE);
    assign mid_due = (mid_off_reg >= -HALF_SAMPLE) && (mid_off_reg < HALF_SAMPLE);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && sym_due)
                begin
                    state_next = ST_MUL_ERR;
                end
            end
            ST_MUL_ERR:  state_next = ST_MUL_GAIN;
            ST_MUL_GAIN: state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready = 1'b0;
        upd_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:     in_ready = 1'b1;
            ST_MUL_ERR:  in_ready = 1'b0;
            ST_MUL_GAIN: in_ready = 1'b0;
            ST_UPDATE:   upd_fire = out_free;
            default:     in_ready = 1'b0;
        endcase
    end

    assign samples.ready = in_ready;
    assign in_fire       = samples.valid && in_ready;
    assign out_free      = !out_valid_reg || symbols.ready;

    assign symbols.valid       = out_valid_reg;
    assign symbols.symbol      = out_symbol_reg;
    assign symbols.symbol_time = out_time_reg;

    // Shared multiplier operands: first (cur - prev) * mid, then |product| * gain.
    assign diff     = DIFF_W'(sample_reg) - DIFF_W'(prev_reg);
    assign prod_neg = prod_reg[PROD_W-1];
    assign mag      = prod_neg ? MAG_W'(-prod_reg) : MAG_W'(prod_reg);

    always_comb
    begin
        if (state_reg == ST_MUL_ERR)
        begin
            mul_a = {{(A_W-DIFF_W){diff[DIFF_W-1]}}, diff};
            mul_b = {{(B_W-SB){mid_reg[SB-1]}}, mid_reg};
        end
        else
        begin
            mul_a = {1'b0, mag};
            mul_b = {{(B_W-GAIN_W){1'b0}}, cfg.loop_gain};
        end
    end

    // A negative product rounds its magnitude up, so the signed error is a floor.
    assign scaled_sum = mul_p[SUM_W-1:0] + (prod_neg ? ROUND_UP : '0);

    // Clamp, then move both points one symbol on.
    assign clamped   = (scaled_reg > {{(SCALED_W-MAXC_W){1'b0}}, cfg.max_correction})
                       ? cfg.max_correction : scaled_reg[MAXC_W-1:0];
    assign err       = neg_reg ? -{{(OFF_W-MAXC_W){1'b0}}, clamped}
                               :  {{(OFF_W-MAXC_W){1'b0}}, clamped};
    assign base      = sym_off_reg - err;
    assign sps_plus1 = {1'b0, cfg.samples_per_symbol} + {{SPS_W{1'b0}}, 1'b1};
    assign half_sps  = sps_plus1[SPS_W:1];

    always_comb
    begin
        sym_off_next   = sym_off_reg;
        mid_off_next   = mid_off_reg;
        prev_next      = prev_reg;
        mid_next       = mid_reg;
        out_valid_next = out_valid_reg;
        if (symbols.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            if (mid_due)
            begin
                mid_next = samples.sample;
            end
            if (!sym_due)
            begin
                sym_off_next = sym_off_reg - ONE_SAMPLE;
                mid_off_next = mid_off_reg - ONE_SAMPLE;
            end
        end
        if (upd_fire)
        begin
            sym_off_next   = base + {{(OFF_W-SPS_W){1'b0}}, cfg.samples_per_symbol}
                             - ONE_SAMPLE;
            mid_off_next   = base + {{(OFF_W-SPS_W){1'b0}}, half_sps} - ONE_SAMPLE;
            prev_next      = sample_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sym_off_reg   <= '0;
            mid_off_reg   <= '0;
            prev_reg      <= '0;
            mid_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sym_off_reg   <= sym_off_next;
            mid_off_reg   <= mid_off_next;
            prev_reg      <= prev_next;
            mid_reg       <= mid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= samples.sample;
            time_reg   <= samples.sample_time;
        end
        if (state_reg == ST_MUL_ERR)
        begin
            prod_reg <= mul_p[PROD_W-1:0];
        end
        if (state_reg == ST_MUL_GAIN)
        begin
            neg_reg    <= prod_neg;
            scaled_reg <= scaled_sum[SUM_W-1:ERR_SH];
        end
        if (upd_fire)
        begin
            out_symbol_reg <= sample_reg;
            out_time_reg   <= time_reg;
        end
    end

    `GSTR_ASSERT_NEXT(a_offsets_hold, !in_fire && !upd_fire,
        $stable(sym_off_reg) && $stable(mid_off_reg), "offsets moved without a sample")
    `GSTR_ASSERT_IMP(a_word_from_update, $rose(out_valid_reg),
        $past(state_reg) == ST_UPDATE, "output word appeared outside the update step")
    `GSTR_ASSERT_NEXT(a_no_word_unless_due, in_fire && !sym_due,
        state_reg == ST_IDLE && !$rose(out_valid_reg), "word produced for a non-symbol sample")

endmodule

`default_nettype wire
